/* src/uts_pkg.sv */
// Package for the unsorted table: sizes, opcode and status codes, the
// controller states and the control bundle that drives the row of cells.
// No dependencies.
package uts_pkg;

   localparam int DEPTH   = 128;
   localparam int VALUE_W = 32;
   localparam int SLOT_W  = $clog2(DEPTH);
   localparam int FILL_W  = $clog2(DEPTH + 1);
   localparam int INDEX_W = 7;
   localparam int COUNT_W = 8;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_SEARCH = 2'd1,
      OP_DELETE = 2'd2,
      OP_CLEAR  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      STS_OK        = 2'd0,
      STS_FULL      = 2'd1,
      STS_NOT_FOUND = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SHIFT
   } state_type;

   typedef struct packed {
      logic start;
      logic step;
      logic copy;
   } cell_ctrl_type;

endpackage

/* src/uts_if.sv */
// Request and response channel interfaces of the unsorted table.
// Depends on uts_pkg for the field types.
interface uts_req_if;
   import uts_pkg::*;

   logic                       valid;
   logic                       ready;
   op_type                     opcode;
   logic signed [VALUE_W-1:0]  item_value;

   modport source (output valid, output opcode, output item_value, input ready);
   modport sink   (input valid, input opcode, input item_value, output ready);
endinterface

interface uts_rsp_if;
   import uts_pkg::*;

   logic               valid;
   logic               ready;
   status_type         status;
   logic [INDEX_W-1:0] match_index;
   logic [COUNT_W-1:0] entry_count;

   modport source (output valid, output status, output match_index, output entry_count,
                   input ready);
   modport sink   (input valid, input status, input match_index, input entry_count,
                   output ready);
endinterface

/* src/uts_cell.sv */
// One cell of the table: holds one entry and one bit of the walking token,
// compares its entry with the search key and can take its right neighbour's entry.
// Depends on uts_pkg.
module uts_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  uts_pkg::cell_ctrl_type        ctrl,
   input  logic                          head,
   input  logic                          wr_en,
   input  logic [uts_pkg::VALUE_W-1:0]   wr_data,
   input  logic [uts_pkg::VALUE_W-1:0]   key,
   input  logic                          tok_prev,
   input  logic [uts_pkg::VALUE_W-1:0]   next_entry,
   output logic [uts_pkg::VALUE_W-1:0]   entry,
   output logic                          tok,
   output logic                          hit
);
   import uts_pkg::*;

   logic [VALUE_W-1:0] entry_ff, entry_in;
   logic               tok_ff, tok_in;

   always_comb begin
      entry_in = entry_ff;
      if (wr_en) begin
         entry_in = wr_data;
      end else if (ctrl.copy && tok_ff) begin
         entry_in = next_entry;
      end
   end

   always_comb begin
      tok_in = tok_ff;
      if (ctrl.start) begin
         tok_in = head;
      end else if (ctrl.step) begin
         tok_in = tok_prev;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff <= 1'b0;
      end else begin
         tok_ff <= tok_in;
      end
   end

   assign entry = entry_ff;
   assign tok   = tok_ff;
   assign hit   = tok_ff && (entry_ff == key);

endmodule

/* src/unsorted_table_insert_search_delete.sv */
// Top level of the unsorted table: controller, response register and the row of cells.
// Depends on uts_pkg, uts_req_if, uts_rsp_if and uts_cell.
//
//   Channel   Direction  Beat contents
//   req_chan  in         opcode, item_value
//   rsp_chan  out        status, match_index, entry_count
//
// Insert and clear give their result in the cycle after the beat is taken.
// Search and delete walk a token along the cells, one cell per cycle: a search
// stops at the first match or at the last entry, a delete always goes on to the last entry,
// as the token goes on past the match to move the later entries down.
// Reset empties the table at once; entries are not cleared. One response is held
// in an output register; a new request is taken while it is being collected.
module unsorted_table_insert_search_delete (
   input  logic       clock,
   input  logic       reset,
   uts_req_if.sink    req_chan,
   uts_rsp_if.source  rsp_chan
);
   import uts_pkg::*;

   state_type           state_ff, state_in;
   logic [FILL_W-1:0]   fill_ff, fill_in;
   logic [SLOT_W-1:0]   k_ff, k_in;
   logic [SLOT_W-1:0]   idx_ff, idx_in;
   logic [VALUE_W-1:0]  key_ff, key_in;
   op_type              op_ff, op_in;
   logic                rsp_valid_ff, rsp_valid_in;
   status_type          rsp_status_ff, rsp_status_in;
   logic [INDEX_W-1:0]  rsp_index_ff, rsp_index_in;
   logic [COUNT_W-1:0]  rsp_count_ff, rsp_count_in;

   cell_ctrl_type       ctrl;
   logic                ins_go;
   logic                req_ready;
   logic                req_take;
   logic                rsp_load;
   logic                hit;
   logic                last;
   logic                full;
   logic [DEPTH-1:0]    wr_en;
   logic [DEPTH-1:0]    tok_vec;
   logic [DEPTH-1:0]    hit_vec;
   logic [VALUE_W-1:0]  entry_vec [DEPTH];

   assign req_ready = !rsp_valid_ff || rsp_chan.ready;
   assign req_take  = req_chan.valid && req_ready && (state_ff == ST_IDLE);
   assign hit       = |hit_vec;
   assign last      = (FILL_W'(k_ff) + FILL_W'(1)) == fill_ff;
   assign full      = fill_ff == FILL_W'(DEPTH);

   always_comb begin
      state_in      = state_ff;
      fill_in       = fill_ff;
      k_in          = k_ff;
      idx_in        = idx_ff;
      key_in        = key_ff;
      op_in         = op_ff;
      ctrl          = '0;
      ins_go        = 1'b0;
      rsp_load      = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_count_in  = rsp_count_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               unique case (req_chan.opcode)
                  OP_INSERT: begin
                     rsp_load     = 1'b1;
                     rsp_index_in = '0;
                     if (full) begin
                        rsp_status_in = STS_FULL;
                        rsp_count_in  = COUNT_W'(fill_ff);
                     end else begin
                        ins_go        = 1'b1;
                        fill_in       = fill_ff + FILL_W'(1);
                        rsp_status_in = STS_OK;
                        rsp_count_in  = COUNT_W'(fill_ff + FILL_W'(1));
                     end
                  end
                  OP_SEARCH, OP_DELETE: begin
                     if (fill_ff == '0) begin
                        rsp_load      = 1'b1;
                        rsp_status_in = STS_NOT_FOUND;
                        rsp_index_in  = '0;
                        rsp_count_in  = '0;
                     end else begin
                        key_in     = req_chan.item_value;
                        op_in      = req_chan.opcode;
                        k_in       = '0;
                        ctrl.start = 1'b1;
                        state_in   = ST_SCAN;
                     end
                  end
                  OP_CLEAR: begin
                     fill_in       = '0;
                     rsp_load      = 1'b1;
                     rsp_status_in = STS_OK;
                     rsp_index_in  = '0;
                     rsp_count_in  = '0;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (hit) begin
               idx_in = k_ff;
               if (op_ff == OP_DELETE) begin
                  ctrl.copy = 1'b1;
                  if (last) begin
                     fill_in       = fill_ff - FILL_W'(1);
                     rsp_load      = 1'b1;
                     rsp_status_in = STS_OK;
                     rsp_index_in  = INDEX_W'(k_ff);
                     rsp_count_in  = COUNT_W'(fill_ff - FILL_W'(1));
                     state_in      = ST_IDLE;
                  end else begin
                     ctrl.step = 1'b1;
                     k_in      = k_ff + SLOT_W'(1);
                     state_in  = ST_SHIFT;
                  end
               end else begin
                  rsp_load      = 1'b1;
                  rsp_status_in = STS_OK;
                  rsp_index_in  = INDEX_W'(k_ff);
                  rsp_count_in  = COUNT_W'(fill_ff);
                  state_in      = ST_IDLE;
               end
            end else if (last) begin
               rsp_load      = 1'b1;
               rsp_status_in = STS_NOT_FOUND;
               rsp_index_in  = '0;
               rsp_count_in  = COUNT_W'(fill_ff);
               state_in      = ST_IDLE;
            end else begin
               ctrl.step = 1'b1;
               k_in      = k_ff + SLOT_W'(1);
            end
         end
         ST_SHIFT: begin
            ctrl.copy = 1'b1;
            if (last) begin
               fill_in       = fill_ff - FILL_W'(1);
               rsp_load      = 1'b1;
               rsp_status_in = STS_OK;
               rsp_index_in  = INDEX_W'(idx_ff);
               rsp_count_in  = COUNT_W'(fill_ff - FILL_W'(1));
               state_in      = ST_IDLE;
            end else begin
               ctrl.step = 1'b1;
               k_in      = k_ff + SLOT_W'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         k_ff         <= k_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      key_ff        <= key_in;
      op_ff         <= op_in;
      rsp_status_ff <= rsp_status_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_count_ff  <= rsp_count_in;
   end

   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      logic               head;
      logic               tok_prev;
      logic [VALUE_W-1:0] next_entry;

      assign wr_en[g] = ins_go && (fill_ff == FILL_W'(g));

      if (g == 0) begin : g_first
         assign head     = 1'b1;
         assign tok_prev = 1'b0;
      end else begin : g_rest
         assign head     = 1'b0;
         assign tok_prev = tok_vec[g-1];
      end

      if (g == DEPTH - 1) begin : g_last
         assign next_entry = entry_vec[g];
      end else begin : g_inner
         assign next_entry = entry_vec[g+1];
      end

      uts_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .head       (head),
         .wr_en      (wr_en[g]),
         .wr_data    (req_chan.item_value),
         .key        (key_ff),
         .tok_prev   (tok_prev),
         .next_entry (next_entry),
         .entry      (entry_vec[g]),
         .tok        (tok_vec[g]),
         .hit        (hit_vec[g])
      );
   end

   assign req_chan.ready       = req_ready && (state_ff == ST_IDLE);
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.status      = rsp_status_ff;
   assign rsp_chan.match_index = rsp_index_ff;
   assign rsp_chan.entry_count = rsp_count_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(DEPTH))
      else $error("Fill count exceeds the table depth.");

   a_token_onehot: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> $onehot(tok_vec))
      else $error("Token is not one-hot during a walk.");

   a_token_place: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> (tok_vec[k_ff] && (FILL_W'(k_ff) < fill_ff)))
      else $error("Token position disagrees with the walk counter.");

   a_delete_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SHIFT && last) |=> (fill_ff == $past(fill_ff) - FILL_W'(1)))
      else $error("Delete did not reduce the fill count by one.");

   a_walk_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req_chan.ready)
      else $error("Request taken during a walk.");

endmodule

/* bench/table_response_checker.sv */
// Response checker for the unsorted table: watches both channels, keeps its own
// copy of the table to predict each response and compares every response beat.
// Depends on uts_pkg and on the uts_req_if and uts_rsp_if interfaces.
module table_response_checker (
   input  logic clock,
   input  logic reset,
   uts_req_if   req_mon,
   uts_rsp_if   rsp_mon,
   output int   fail_count,
   output int   outstanding
);
   import uts_pkg::*;

   typedef struct {
      status_type         status;
      logic [INDEX_W-1:0] index;
      logic [COUNT_W-1:0] count;
   } table_result_type;

   logic [VALUE_W-1:0] stored_values[$];
   table_result_type   expected_results[$];
   table_result_type   oldest_expected;
   int                 errors = 0;

   assign fail_count = errors;

   function automatic table_result_type predict_response(input op_type op,
                                                         input logic [VALUE_W-1:0] value);
      table_result_type r;
      int               hit;
      r.status = STS_OK;
      r.index  = '0;
      hit      = -1;
      if (op == OP_SEARCH || op == OP_DELETE) begin
         foreach (stored_values[i]) begin
            if (hit < 0 && stored_values[i] == value) begin
               hit = i;
            end
         end
      end
      case (op)
         OP_INSERT: begin
            if (stored_values.size() >= DEPTH) begin
               r.status = STS_FULL;
            end else begin
               stored_values.push_back(value);
            end
         end
         OP_SEARCH, OP_DELETE: begin
            if (hit < 0) begin
               r.status = STS_NOT_FOUND;
            end else begin
               r.index = INDEX_W'(hit);
               if (op == OP_DELETE) begin
                  stored_values.delete(hit);
               end
            end
         end
         OP_CLEAR: begin
            stored_values.delete();
         end
         default: begin
         end
      endcase
      r.count = COUNT_W'(stored_values.size());
      return r;
   endfunction

   task automatic check_field(input string field, input logic [31:0] expected,
                              input logic [31:0] actual);
      if (expected !== actual) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field,
                  expected, actual);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         stored_values.delete();
         expected_results.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected response beat, expected none, %s %0d %0d %0d",
                        $time, "actual status, index and count", rsp_mon.status,
                        rsp_mon.match_index, rsp_mon.entry_count);
               errors++;
            end else begin
               oldest_expected = expected_results.pop_front();
               check_field("status", oldest_expected.status, rsp_mon.status);
               check_field("match_index", oldest_expected.index, rsp_mon.match_index);
               check_field("entry_count", oldest_expected.count, rsp_mon.entry_count);
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            expected_results.push_back(predict_response(req_mon.opcode, req_mon.item_value));
         end
      end
      outstanding <= expected_results.size();
   end

endmodule

/* bench/tb_top.sv */
// Top of the unsorted table testbench: clock, reset, request and response traffic
// with random gaps, and the verdict. Depends on uts_pkg, the channel interfaces,
// the table itself and table_response_checker.
module tb_top;
   import uts_pkg::*;

   localparam int ITEM_TARGET  = 1600;
   localparam int PHASE_LEN    = 100;
   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int DRAIN_CYCLES = 300;
   localparam int LONG_HOLD    = 400;

   localparam int MODE_MIXED = 0;
   localparam int MODE_FILL  = 1;
   localparam int MODE_EMPTY = 2;

   logic clock = 1'b0;
   logic reset;
   int   fail_count;
   int   outstanding;
   int   cycle_count = 0;
   int   hold_requests = 0;
   int   items_sent = 0;
   bit   no_idle = 1'b0;
   int   mode;

   logic [VALUE_W-1:0] value_pool[16];

   uts_req_if req_chan();
   uts_rsp_if rsp_chan();

   unsorted_table_insert_search_delete DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   table_response_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_chan),
      .rsp_mon     (rsp_chan),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_top failed");
         $finish;
      end
   end

   task automatic send_request(input op_type op, input logic [VALUE_W-1:0] value);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.opcode     <= op;
      req_chan.item_value <= value;
      do @(posedge clock); while (!req_chan.ready);
      items_sent++;
   endtask

   task automatic wait_for_results();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   function automatic logic [VALUE_W-1:0] pick_value();
      if ($urandom_range(0, 9) < 6) begin
         return value_pool[4'($urandom_range(0, 15))];
      end
      return $urandom();
   endfunction

   function automatic op_type pick_op(input int phase_mode);
      int roll;
      roll = $urandom_range(0, 99);
      case (phase_mode)
         MODE_FILL: begin
            if (roll < 80) return OP_INSERT;
            if (roll < 90) return OP_SEARCH;
            if (roll < 99) return OP_DELETE;
         end
         MODE_EMPTY: begin
            if (roll < 15) return OP_INSERT;
            if (roll < 35) return OP_SEARCH;
            if (roll < 99) return OP_DELETE;
         end
         default: begin
            if (roll < 40) return OP_INSERT;
            if (roll < 70) return OP_SEARCH;
            if (roll < 98) return OP_DELETE;
         end
      endcase
      return OP_CLEAR;
   endfunction

   // The receiver idles per beat and, when asked, holds off for a long stretch.
   initial begin
      int holds_done;
      int stall;
      holds_done = 0;
      rsp_chan.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (hold_requests != holds_done) begin
            holds_done = hold_requests;
            rsp_chan.ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else begin
            stall = no_idle ? 0 : $urandom_range(0, 10);
            if (stall > 0) begin
               rsp_chan.ready <= 1'b0;
               repeat (stall) @(posedge clock);
            end
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!rsp_chan.valid);
      end
   end

   initial begin
      reset               <= 1'b1;
      req_chan.valid      <= 1'b0;
      req_chan.opcode     <= OP_INSERT;
      req_chan.item_value <= '0;
      value_pool[0] = 32'h8000_0000;
      value_pool[1] = 32'h7FFF_FFFF;
      value_pool[2] = 32'h0000_0000;
      value_pool[3] = 32'hFFFF_FFFF;
      value_pool[4] = 32'h0000_0001;
      for (int i = 5; i < 16; i++) begin
         value_pool[4'(i)] = $urandom();
      end
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      send_request(OP_CLEAR, 32'h0);
      send_request(OP_SEARCH, 32'h0);
      send_request(OP_DELETE, 32'h0);
      send_request(OP_INSERT, 32'h8000_0000);
      send_request(OP_INSERT, 32'h7FFF_FFFF);
      send_request(OP_INSERT, 32'h0000_0000);
      send_request(OP_INSERT, 32'hFFFF_FFFF);
      send_request(OP_INSERT, 32'h7FFF_FFFF);
      send_request(OP_SEARCH, 32'h7FFF_FFFF);
      send_request(OP_SEARCH, 32'h1234_5678);
      send_request(OP_DELETE, 32'h8000_0000);
      send_request(OP_SEARCH, 32'hFFFF_FFFF);
      send_request(OP_DELETE, 32'h7FFF_FFFF);
      send_request(OP_DELETE, 32'h7FFF_FFFF);
      send_request(OP_DELETE, 32'h5555_AAAA);
      send_request(OP_INSERT, 32'h0000_0005);
      send_request(OP_CLEAR, 32'hFFFF_FFFF);
      send_request(OP_SEARCH, 32'h0000_0005);
      send_request(OP_INSERT, 32'h0000_0005);
      send_request(OP_SEARCH, 32'h0000_0005);
      send_request(OP_DELETE, 32'h0000_0005);
      wait_for_results();

      // Fill the table past its capacity, then work on the full table.
      repeat (140) send_request(OP_INSERT, pick_value());
      repeat (20) send_request(pick_op(MODE_MIXED), pick_value());
      wait_for_results();

      // Keep offering beats while the response side is held off.
      hold_requests <= hold_requests + 1;
      no_idle <= 1'b1;
      repeat (60) send_request(pick_op(MODE_MIXED), pick_value());
      no_idle <= 1'b0;
      wait_for_results();

      while (items_sent < ITEM_TARGET) begin
         mode = $urandom_range(MODE_MIXED, MODE_EMPTY);
         no_idle <= ($urandom_range(0, 3) == 0);
         repeat (PHASE_LEN) send_request(pick_op(mode), pick_value());
         if ($urandom_range(0, 1) == 1) begin
            wait_for_results();
         end
      end

      wait_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && outstanding == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

endmodule

/* files.f */
src/uts_pkg.sv
src/uts_if.sv
src/uts_cell.sv
src/unsorted_table_insert_search_delete.sv
bench/table_response_checker.sv
bench/tb_top.sv
